### rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher core.
package rc4_pkg;

   // Field widths fixed by the request and response formats
   localparam int BYTE_W = 8;

   // Command queue between front end and engine
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;

   // Request classes decoded by the front end
   typedef enum logic [1:0] {
      OP_KEY      = 2'd0,
      OP_KEY_LAST = 2'd1,
      OP_DATA     = 2'd2
   } op_type;

   // One decoded request as it travels through the queue
   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] value;
   } cmd_type;

   // Head of the command queue as seen by the engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

endpackage

### rtl/core/rc4_if.sv
// Request and response channel interfaces of the RC4 stream cipher core.
interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] value;
   logic       key_last;

   modport source (output valid, output func, output value, output key_last, input ready);
   modport sink   (input valid, input func, input value, input key_last, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_out;
   logic [7:0] keystream_byte;

   modport source (output valid, output data_out, output keystream_byte, input ready);
   modport sink   (input valid, input data_out, input keystream_byte, output ready);
endinterface

### rtl/core/rc4_front.sv
// Front end: registers incoming requests and decodes them into commands.
module rc4_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               init_done,
   rc4_req_if.sink            req_chan,
   output logic               push_valid,
   output rc4_pkg::cmd_type   push_cmd,
   input  logic               push_ready
);
   import rc4_pkg::*;

   logic    cmd_valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    req_take;

   // Once the initial fill is done, stage takes a request when empty or when its content moves on
   assign req_chan.ready = init_done && (!cmd_valid_ff || push_ready);
   assign req_take       = req_chan.valid && req_chan.ready;

   // Decode: data request, plain key byte, or final key byte
   always_comb begin
      cmd_in.value = req_chan.value;
      priority if (req_chan.func)     cmd_in.op = OP_DATA;
      else if     (req_chan.key_last) cmd_in.op = OP_KEY_LAST;
      else                            cmd_in.op = OP_KEY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else if (req_take) begin
         cmd_valid_ff <= 1'b1;
      end else if (push_ready) begin
         cmd_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

### rtl/core/rc4_cmd_fifo.sv
// Short command queue that decouples the front end from the engine.
module rc4_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  rc4_pkg::cmd_type     push_cmd,
   output logic                 push_ready,
   output rc4_pkg::q_head_type  head,
   input  logic                 pop
);
   import rc4_pkg::*;

   cmd_type               mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W:0]   count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + (FIFO_PTR_W+1)'(1);
            2'b01:   count_ff <= count_ff - (FIFO_PTR_W+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/rc4_engine.sv
// Back end: permutation and key memories, key schedule and keystream sequencer.
module rc4_engine #(
   parameter int STATE_SIZE = 256,
   parameter int KEY_MAX    = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rc4_pkg::q_head_type  head,
   output logic                 pop,
   output logic                 init_done,
   rc4_rsp_if.source            rsp_chan
);
   import rc4_pkg::*;

   localparam int IDX_W = $clog2(STATE_SIZE);
   localparam int KEY_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int LEN_W = $clog2(KEY_MAX + 1);
   // ceil(2^16 / STATE_SIZE): exact quotient for any byte divided by STATE_SIZE
   localparam int RECIP = (65536 + STATE_SIZE - 1) / STATE_SIZE;
   localparam logic [IDX_W:0]   N_EXT    = (IDX_W+1)'(STATE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_SIZE - 1);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(KEY_MAX);

   typedef enum logic [3:0] {
      ST_INIT,     // identity fill after reset
      ST_IDLE,
      ST_KEY_MUL,
      ST_KEY_WR,
      ST_FILL,     // identity fill before the key schedule
      ST_KS_RD,
      ST_KS_J,
      ST_KS_WA,
      ST_KS_WB,
      ST_GEN_A,
      ST_GEN_B,
      ST_GEN_C,
      ST_GEN_D,
      ST_GEN_E
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [IDX_W-1:0]   n_ff;
   logic [IDX_W-1:0]   i_ff;
   logic [IDX_W-1:0]   j_ff;
   logic [IDX_W-1:0]   si_ff;
   logic [IDX_W-1:0]   sj_ff;
   logic [IDX_W-1:0]   t_ff;
   logic [LEN_W-1:0]   key_len_ff;
   logic [KEY_W-1:0]   kidx_ff;
   logic [KEY_W-1:0]   klast_ff;
   logic [BYTE_W-1:0]  q_ff;
   logic               rsp_valid_ff;
   logic [BYTE_W-1:0]  data_out_ff;
   logic [BYTE_W-1:0]  ks_ff;

   // Memories
   logic [IDX_W-1:0]   perm_mem [STATE_SIZE];
   logic [IDX_W-1:0]   key_mem  [KEY_MAX];
   logic [IDX_W-1:0]   perm_rdata_ff;
   logic [IDX_W-1:0]   key_rdata_ff;
   logic               perm_we;
   logic [IDX_W-1:0]   perm_waddr;
   logic [IDX_W-1:0]   perm_wdata;
   logic [IDX_W-1:0]   perm_raddr;
   logic               key_we;

   logic [IDX_W-1:0]   i_next;
   logic [IDX_W-1:0]   j_gen_next;
   logic [IDX_W-1:0]   t_next;
   logic [IDX_W-1:0]   j_ks_next;
   logic [IDX_W-1:0]   ks_idx;
   logic               key_room;
   logic [LEN_W-1:0]   key_len_next;
   logic [24:0]        key_prod;
   logic [15:0]        key_qn;
   logic [15:0]        key_rem;
   logic               rsp_free;
   logic               rsp_load;

   // Sum of two indices modulo the state size (both below it)
   function automatic logic [IDX_W-1:0] mod_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= N_EXT) s = s - N_EXT;
      return s[IDX_W-1:0];
   endfunction

   // Index arithmetic
   assign i_next     = (i_ff == LAST_IDX) ? '0 : i_ff + IDX_W'(1);
   assign j_gen_next = mod_add(j_ff, perm_rdata_ff);
   assign t_next     = mod_add(si_ff, perm_rdata_ff);
   assign j_ks_next  = mod_add(mod_add(j_ff, perm_rdata_ff), key_rdata_ff);
   // The swap of S[j] lands in the same cycle as the read of S[t]
   assign ks_idx     = (t_ff == j_ff) ? si_ff : perm_rdata_ff;

   // Key byte reduced modulo the state size by reciprocal multiply
   assign key_prod     = 25'(cmd_ff.value) * 25'(RECIP);
   assign key_qn       = 16'(q_ff) * 16'(STATE_SIZE);
   assign key_rem      = 16'(cmd_ff.value) - key_qn;
   assign key_room     = (key_len_ff < LEN_MAX);
   assign key_len_next = key_room ? key_len_ff + LEN_W'(1) : key_len_ff;
   assign key_we       = (state_ff == ST_KEY_WR) && key_room;

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load  = (state_ff == ST_GEN_E) && rsp_free;
   assign pop       = (state_ff == ST_IDLE) && head.valid;
   assign init_done = (state_ff != ST_INIT);

   // Permutation memory port selection
   always_comb begin
      perm_we    = 1'b0;
      perm_waddr = n_ff;
      perm_wdata = n_ff;
      perm_raddr = n_ff;
      unique case (state_ff)
         ST_INIT, ST_FILL: begin
            perm_we = 1'b1;
         end
         ST_KS_J: begin
            perm_raddr = j_ks_next;
         end
         ST_KS_WA: begin
            perm_we    = 1'b1;
            perm_wdata = perm_rdata_ff;
         end
         ST_KS_WB: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = sj_ff;
         end
         ST_GEN_A: begin
            perm_raddr = i_next;
         end
         ST_GEN_B: begin
            perm_raddr = j_gen_next;
         end
         ST_GEN_C: begin
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rdata_ff;
         end
         ST_GEN_D: begin
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            perm_raddr = t_ff;
         end
         ST_GEN_E: begin
            perm_raddr = t_ff;
         end
         default: begin
            perm_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (perm_we) perm_mem[perm_waddr] <= perm_wdata;
      perm_rdata_ff <= perm_mem[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_len_ff[KEY_W-1:0]] <= key_rem[IDX_W-1:0];
      key_rdata_ff <= key_mem[kidx_ff];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         kidx_ff      <= '0;
         key_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Response register: load a finished step, drop once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_INIT: begin
               if (n_ff == LAST_IDX) begin
                  n_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff <= n_ff + IDX_W'(1);
               end
            end
            ST_IDLE: begin
               if (head.valid) begin
                  cmd_ff   <= head.cmd;
                  state_ff <= (head.cmd.op == OP_DATA) ? ST_GEN_A : ST_KEY_MUL;
               end
            end
            ST_KEY_MUL: begin
               q_ff     <= key_prod[23:16];
               state_ff <= ST_KEY_WR;
            end
            ST_KEY_WR: begin
               if (cmd_ff.op == OP_KEY_LAST) begin
                  klast_ff   <= KEY_W'(key_len_next - LEN_W'(1));
                  key_len_ff <= '0;
                  kidx_ff    <= '0;
                  n_ff       <= '0;
                  i_ff       <= '0;
                  j_ff       <= '0;
                  state_ff   <= ST_FILL;
               end else begin
                  key_len_ff <= key_len_next;
                  state_ff   <= ST_IDLE;
               end
            end
            ST_FILL: begin
               if (n_ff == LAST_IDX) begin
                  n_ff     <= '0;
                  state_ff <= ST_KS_RD;
               end else begin
                  n_ff <= n_ff + IDX_W'(1);
               end
            end
            ST_KS_RD: begin
               state_ff <= ST_KS_J;
            end
            ST_KS_J: begin
               sj_ff    <= perm_rdata_ff;
               j_ff     <= j_ks_next;
               state_ff <= ST_KS_WA;
            end
            ST_KS_WA: begin
               state_ff <= ST_KS_WB;
            end
            ST_KS_WB: begin
               kidx_ff <= (kidx_ff == klast_ff) ? '0 : kidx_ff + KEY_W'(1);
               if (n_ff == LAST_IDX) begin
                  n_ff     <= '0;
                  j_ff     <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  n_ff     <= n_ff + IDX_W'(1);
                  state_ff <= ST_KS_RD;
               end
            end
            ST_GEN_A: begin
               i_ff     <= i_next;
               state_ff <= ST_GEN_B;
            end
            ST_GEN_B: begin
               si_ff    <= perm_rdata_ff;
               j_ff     <= j_gen_next;
               state_ff <= ST_GEN_C;
            end
            ST_GEN_C: begin
               t_ff     <= t_next;
               state_ff <= ST_GEN_D;
            end
            ST_GEN_D: begin
               state_ff <= ST_GEN_E;
            end
            ST_GEN_E: begin
               if (rsp_free) begin
                  ks_ff       <= BYTE_W'(ks_idx);
                  data_out_ff <= cmd_ff.value ^ BYTE_W'(ks_idx);
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.data_out       = data_out_ff;
   assign rsp_chan.keystream_byte = ks_ff;

   // A command leaves the queue only when one is there
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("engine popped an empty command queue");

   // Key length never passes the store size
   a_key_len_bound: assert property (@(posedge clock) disable iff (reset)
      key_len_ff <= LEN_MAX)
      else $error("key length beyond key store size");

   // A finished keystream step always delivers its response next cycle
   a_gen_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GEN_E && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("keystream result not registered");

   // No permutation write while idle
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !perm_we)
      else $error("permutation written while idle");

endmodule

### rtl/core/rc4_stream_cipher_core.sv
// RC4 stream cipher core: top level tying front end, command queue and engine.
//
// Requests carry a key byte (func = 0) or a data byte (func = 1). Key bytes
// are stored until the store is full; later ones are dropped. A key byte with
// key_last set stores that byte and then runs the key schedule over a
// STATE_SIZE-entry permutation, which also clears the generator indices.
// Each data request produces one response with the data byte XORed with the
// keystream byte and the keystream byte itself; key requests produce none.
// After reset the core loads the identity permutation and holds req ready
// low meanwhile. A key byte passes the idle, multiply and write states; a
// final key byte then runs the identity fill and, per shuffle step, the read,
// index, write and write states on the single-write permutation memory. A
// data byte runs the read, read, write, write, read sequence of the generator
// step against that memory. A two-entry command queue lets requests be taken
// while the engine works or a response waits.
module rc4_stream_cipher_core #(
   parameter int STATE_SIZE = 256,
   parameter int KEY_MAX    = 256
) (
   input  logic        clock,
   input  logic        reset,
   rc4_req_if.sink     req_chan,
   rc4_rsp_if.source   rsp_chan
);
   import rc4_pkg::*;

   logic       init_done;
   logic       push_valid;
   logic       push_ready;
   cmd_type    push_cmd;
   q_head_type head;
   logic       pop;

   rc4_front u_front (
      .clock      (clock),
      .reset      (reset),
      .init_done  (init_done),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   rc4_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   rc4_engine #(
      .STATE_SIZE (STATE_SIZE),
      .KEY_MAX    (KEY_MAX)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .init_done (init_done),
      .rsp_chan  (rsp_chan)
   );

endmodule
